// ===== src/scaled_font_text_pixel_generator_assert.svh =====
// assertion macros for the scaled font text pixel generator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SCALED_FONT_TEXT_PIXEL_GENERATOR_ASSERT_SVH
`define SCALED_FONT_TEXT_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define SFG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfg assertion failed");

// next-cycle implication, off during reset
`define SFG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfg assertion failed");

// next-cycle implication, also checked across reset
`define SFG_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sfg assertion failed");

`endif

// ===== src/sfg_pkg.sv =====
// shared constants, codes and beat structs of the scaled font text pixel generator
// no dependencies
`default_nettype none

package sfg_pkg;

  // sizing
  localparam int MAX_CHARS     = 32;
  localparam int GLYPH_ENTRIES = 256;
  localparam int GLYPH_WIDTH   = 5;
  localparam int GLYPH_HEIGHT  = 7;
  localparam int MAX_SCALE     = 8;
  localparam int CELL_COLUMNS  = GLYPH_WIDTH + 1;
  localparam int SPACE_CODE    = 32;

  // field widths
  localparam int CMD_W      = 2;
  localparam int CODE_W     = 8;
  localparam int GLYPH_BITS = GLYPH_WIDTH * GLYPH_HEIGHT;
  localparam int TEXT_POS_W = 5;
  localparam int COLOR_W    = 16;
  localparam int SCALE_W    = 4;
  localparam int LENGTH_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 56;

  // derived widths
  localparam int CHAR_AW   = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LEN_W     = $clog2(MAX_CHARS + 1);
  localparam int GLYPH_AW  = $clog2(GLYPH_ENTRIES);
  localparam int SC_W      = $clog2(MAX_SCALE + 1);
  localparam int REP_W     = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int ROW_W     = $clog2(GLYPH_HEIGHT * MAX_SCALE);
  localparam int ROWLIM_W  = $clog2(GLYPH_HEIGHT * MAX_SCALE + 1);
  localparam int FROW_W    = 3;
  localparam int COL_W     = 3;
  localparam int BIT_IDX_W = 6;

  // space fallback glyph
  localparam bit SPACE_OK = (SPACE_CODE < GLYPH_ENTRIES);
  localparam logic [GLYPH_AW-1:0] SPACE_IDX = SPACE_OK ? GLYPH_AW'(SPACE_CODE) : '0;

  // reset values of the registers
  localparam logic [COLOR_W-1:0]  FG_RESET     = 16'hFFFF;
  localparam logic [COLOR_W-1:0]  BG_RESET     = 16'h0000;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 4'd1;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 6'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_GLYPH = 2'd0,
    CMD_LOAD_TEXT  = 2'd1,
    CMD_PIXEL      = 2'd2,
    CMD_RESTART    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_COLOR    = 2'd0,
    REG_BG_COLOR    = 2'd1,
    REG_SCALE       = 2'd2,
    REG_TEXT_LENGTH = 2'd3
  } cfg_reg_t;

  // per-pixel control travelling down the lookup pipeline
  typedef struct packed {
    logic [FROW_W-1:0] font_row;
    logic [COL_W-1:0]  col;
    logic              gap;
    logic              row_end;
    logic              window_end;
  } pix_info_t;

  // pixel decision handed to the output buffer
  typedef struct packed {
    logic lit;
    logic row_end;
    logic window_end;
  } pix_res_t;

  // one output beat
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               row_end;
    logic               window_end;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== src/sfg_raster.sv =====
// raster position counters: character, cell column, replication and row
// depends on sfg_pkg
`default_nettype none

module sfg_raster (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic                          restart,
  input  wire logic [sfg_pkg::SC_W-1:0]      scale_eff,
  input  wire logic [sfg_pkg::LEN_W-1:0]     len_eff,
  output logic      [sfg_pkg::CHAR_AW-1:0]   char_idx,
  output sfg_pkg::pix_info_t                 info
);

  logic [sfg_pkg::CHAR_AW-1:0]  char_r, char_nxt, c_char;
  logic [sfg_pkg::COL_W-1:0]    col_r, col_nxt, c_col;
  logic [sfg_pkg::REP_W-1:0]    rep_r, rep_nxt, c_rep;
  logic [sfg_pkg::ROW_W-1:0]    row_r, row_nxt, c_row;
  logic [sfg_pkg::ROWLIM_W-1:0] rows_total;
  logic [sfg_pkg::FROW_W-1:0]   font_row;
  logic                         oob, last_in_row, last_row;

  // window limits and out-of-window restart
  always_comb begin
    rows_total = sfg_pkg::ROWLIM_W'(sfg_pkg::GLYPH_HEIGHT) * sfg_pkg::ROWLIM_W'(scale_eff);
    oob = (sfg_pkg::LEN_W'(char_r) >= len_eff) ||
          (col_r >= sfg_pkg::COL_W'(sfg_pkg::CELL_COLUMNS)) ||
          (sfg_pkg::SC_W'(rep_r) >= scale_eff) ||
          (sfg_pkg::ROWLIM_W'(row_r) >= rows_total);
    c_char = oob ? '0 : char_r;
    c_col  = oob ? '0 : col_r;
    c_rep  = oob ? '0 : rep_r;
    c_row  = oob ? '0 : row_r;
  end

  // glyph row = row / scale, by comparing against the six row boundaries
  always_comb begin
    font_row = '0;
    for (int k = 1; k < sfg_pkg::GLYPH_HEIGHT; k++) begin
      if (sfg_pkg::ROWLIM_W'(c_row) >=
          sfg_pkg::ROWLIM_W'(k) * sfg_pkg::ROWLIM_W'(scale_eff)) begin
        font_row = font_row + sfg_pkg::FROW_W'(1);
      end
    end
  end

  // end-of-row and end-of-window flags
  always_comb begin
    last_in_row = (sfg_pkg::LEN_W'(c_char) == len_eff - sfg_pkg::LEN_W'(1)) &&
                  (c_col == sfg_pkg::COL_W'(sfg_pkg::CELL_COLUMNS - 1)) &&
                  (sfg_pkg::SC_W'(c_rep) == scale_eff - sfg_pkg::SC_W'(1));
    last_row    = (sfg_pkg::ROWLIM_W'(c_row) == rows_total - sfg_pkg::ROWLIM_W'(1));
  end

  // advance to the next pixel
  always_comb begin
    char_nxt = c_char;
    col_nxt  = c_col;
    rep_nxt  = c_rep;
    row_nxt  = c_row;
    if (last_in_row) begin
      char_nxt = '0;
      col_nxt  = '0;
      rep_nxt  = '0;
      row_nxt  = last_row ? '0 : c_row + sfg_pkg::ROW_W'(1);
    end else if (sfg_pkg::SC_W'(c_rep) + sfg_pkg::SC_W'(1) < scale_eff) begin
      rep_nxt = c_rep + sfg_pkg::REP_W'(1);
    end else begin
      rep_nxt = '0;
      if (c_col + sfg_pkg::COL_W'(1) < sfg_pkg::COL_W'(sfg_pkg::CELL_COLUMNS)) begin
        col_nxt = c_col + sfg_pkg::COL_W'(1);
      end else begin
        col_nxt  = '0;
        char_nxt = c_char + sfg_pkg::CHAR_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      char_r <= '0;
      col_r  <= '0;
      rep_r  <= '0;
      row_r  <= '0;
    end else if (step) begin
      char_r <= char_nxt;
      col_r  <= col_nxt;
      rep_r  <= rep_nxt;
      row_r  <= row_nxt;
    end
  end

  assign char_idx        = c_char;
  assign info.font_row   = font_row;
  assign info.col        = c_col;
  assign info.gap        = (c_col >= sfg_pkg::COL_W'(sfg_pkg::GLYPH_WIDTH));
  assign info.row_end    = last_in_row;
  assign info.window_end = last_in_row && last_row;

endmodule

`default_nettype wire

// ===== src/sfg_glyph_lookup.sv =====
// text store and glyph store with loaded flags, two-stage read pipeline
// depends on sfg_pkg
`default_nettype none

module sfg_glyph_lookup (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              adv,
  input  wire logic                              tick,
  input  wire sfg_pkg::pix_info_t                info_in,
  input  wire logic [sfg_pkg::CHAR_AW-1:0]       char_idx,
  input  wire logic                              text_we,
  input  wire logic [sfg_pkg::CHAR_AW-1:0]       text_addr,
  input  wire logic [sfg_pkg::CODE_W-1:0]        text_data,
  input  wire logic                              glyph_we,
  input  wire logic [sfg_pkg::GLYPH_AW-1:0]      glyph_addr,
  input  wire logic [sfg_pkg::GLYPH_BITS-1:0]    glyph_data,
  output logic                                   res_valid,
  output sfg_pkg::pix_res_t                      res
);

  logic [sfg_pkg::CODE_W-1:0]     text_mem [sfg_pkg::MAX_CHARS];
  logic [sfg_pkg::GLYPH_BITS-1:0] glyph_mem [sfg_pkg::GLYPH_ENTRIES];
  logic [sfg_pkg::GLYPH_ENTRIES-1:0] loaded_r;

  logic [sfg_pkg::CODE_W-1:0]     txt_rd_r;
  logic [sfg_pkg::GLYPH_BITS-1:0] glyph_rd_r;
  logic                           s1_valid_r, s2_valid_r;
  sfg_pkg::pix_info_t             s1_info_r, s2_info_r, s1_info_q;

  logic [sfg_pkg::GLYPH_AW-1:0]   code_idx, rd_addr;
  logic                           code_ok, code_loaded, space_loaded, blank;
  logic [sfg_pkg::BIT_IDX_W-1:0]  bit_idx;
  logic [63:0]                    glyph_ext;

  // text store: write on load beat, read at the character under the raster
  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_addr] <= text_data;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      txt_rd_r <= text_mem[char_idx];
    end
  end

  // glyph store and its loaded flags
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_addr] <= glyph_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else if (glyph_we) begin
      loaded_r[glyph_addr] <= 1'b1;
    end
  end

  // pick the code's glyph, else space, else blank
  always_comb begin
    code_idx     = sfg_pkg::GLYPH_AW'(txt_rd_r);
    code_ok      = (int'(txt_rd_r) < sfg_pkg::GLYPH_ENTRIES);
    code_loaded  = code_ok && loaded_r[code_idx];
    space_loaded = sfg_pkg::SPACE_OK && loaded_r[sfg_pkg::SPACE_IDX];
    rd_addr      = code_loaded ? code_idx : sfg_pkg::SPACE_IDX;
    blank        = !code_loaded && !space_loaded;
    s1_info_q     = s1_info_r;
    s1_info_q.gap = s1_info_r.gap || blank;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      glyph_rd_r <= glyph_mem[rd_addr];
      s1_info_r  <= info_in;
      s2_info_r  <= s1_info_q;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= tick;
      s2_valid_r <= s1_valid_r;
    end
  end

  // glyph bit at column*height + row
  always_comb begin
    bit_idx   = sfg_pkg::BIT_IDX_W'(s2_info_r.col) * sfg_pkg::BIT_IDX_W'(sfg_pkg::GLYPH_HEIGHT) +
                sfg_pkg::BIT_IDX_W'(s2_info_r.font_row);
    glyph_ext = 64'(glyph_rd_r);
    res.lit        = !s2_info_r.gap && glyph_ext[bit_idx];
    res.row_end    = s2_info_r.row_end;
    res.window_end = s2_info_r.window_end;
  end

  assign res_valid = s2_valid_r;

endmodule

`default_nettype wire

// ===== src/sfg_out_buf.sv =====
// output register with skid stage, colors applied on entry
// depends on sfg_pkg
`default_nettype none

module sfg_out_buf (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          res_valid,
  input  wire sfg_pkg::pix_res_t             res,
  input  wire logic [sfg_pkg::COLOR_W-1:0]   fg_color,
  input  wire logic [sfg_pkg::COLOR_W-1:0]   bg_color,
  input  wire logic                          out_tready,
  output logic                               out_tvalid,
  output sfg_pkg::out_beat_t                 out_beat,
  output logic                               adv
);

  sfg_pkg::out_beat_t out_r, skid_r, new_beat;
  logic               out_v_r, skid_v_r, take;

  always_comb begin
    new_beat.color      = res.lit ? fg_color : bg_color;
    new_beat.row_end    = res.row_end;
    new_beat.window_end = res.window_end;
    take = out_v_r && out_tready;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_v_r || take) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_r <= skid_r;
      end
    end else if (res_valid) begin
      if (!out_v_r || take) begin
        out_r <= new_beat;
      end else begin
        skid_r <= new_beat;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_beat   = out_r;
  assign adv        = !skid_v_r;

endmodule

`default_nettype wire

// ===== src/scaled_font_text_pixel_generator.sv =====
// top level of the scaled font text pixel generator: config registers, beat decode
// depends on sfg_pkg, sfg_raster, sfg_glyph_lookup, sfg_out_buf
`default_nettype none

// Draws a text string in a 5x7 bitmap font, one pixel per pixel-tick beat, in
// raster order over a window of text_length*6*scale by 7*scale pixels. Glyph and
// text loads and raster restarts produce no output beat. The block takes one
// beat every clock unless stalled; a pixel beat's color passes through the text
// store read, the glyph store read and the output register before it leaves.
// Input stalls only when the output register and its skid stage are both full.
// Loaded-glyph flags reset at once, so no clearing pass follows reset.

module scaled_font_text_pixel_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: glyph_code[7:0], glyph_columns[42:8], text_pos[47:43], text_char[55:48]
  input  wire logic [55:0] in_tdata,
  // in_tuser: cmd[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: pixel_color[15:0]
  output logic [15:0]      out_tdata,
  // out_tuser: window_end[0]
  output logic             out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [sfg_pkg::COLOR_W-1:0]  fg_r, bg_r;
  logic [sfg_pkg::SCALE_W-1:0]  scale_r;
  logic [sfg_pkg::LENGTH_W-1:0] length_r;
  logic [sfg_pkg::SC_W-1:0]     scale_eff;
  logic [sfg_pkg::LEN_W-1:0]    len_eff;

  sfg_pkg::cmd_t                cmd;
  logic                         in_acc, adv;
  logic                         tick, restart, text_we, glyph_we;
  logic [sfg_pkg::CODE_W-1:0]   glyph_code, text_char;
  logic [sfg_pkg::TEXT_POS_W-1:0] text_pos;
  logic [sfg_pkg::GLYPH_BITS-1:0] glyph_cols;

  logic [sfg_pkg::CHAR_AW-1:0]  char_idx;
  sfg_pkg::pix_info_t           info;
  logic                         res_valid;
  sfg_pkg::pix_res_t            res;
  sfg_pkg::out_beat_t           out_beat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r     <= sfg_pkg::FG_RESET;
      bg_r     <= sfg_pkg::BG_RESET;
      scale_r  <= sfg_pkg::SCALE_RESET;
      length_r <= sfg_pkg::LENGTH_RESET;
    end else if (cfg_valid) begin
      unique case (sfg_pkg::cfg_reg_t'(cfg_index))
        sfg_pkg::REG_FG_COLOR:    fg_r     <= cfg_data;
        sfg_pkg::REG_BG_COLOR:    bg_r     <= cfg_data;
        sfg_pkg::REG_SCALE:       scale_r  <= cfg_data[sfg_pkg::SCALE_W-1:0];
        sfg_pkg::REG_TEXT_LENGTH: length_r <= cfg_data[sfg_pkg::LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // clamp scale and length into their working range
  always_comb begin
    if (scale_r == '0) begin
      scale_eff = sfg_pkg::SC_W'(1);
    end else if (int'(scale_r) > sfg_pkg::MAX_SCALE) begin
      scale_eff = sfg_pkg::SC_W'(sfg_pkg::MAX_SCALE);
    end else begin
      scale_eff = sfg_pkg::SC_W'(scale_r);
    end
    if (length_r == '0) begin
      len_eff = sfg_pkg::LEN_W'(1);
    end else if (int'(length_r) > sfg_pkg::MAX_CHARS) begin
      len_eff = sfg_pkg::LEN_W'(sfg_pkg::MAX_CHARS);
    end else begin
      len_eff = sfg_pkg::LEN_W'(length_r);
    end
  end

  // input beat decode
  always_comb begin
    in_acc     = in_tvalid && in_tready;
    cmd        = sfg_pkg::cmd_t'(in_tuser);
    glyph_code = in_tdata[7:0];
    glyph_cols = in_tdata[42:8];
    text_pos   = in_tdata[47:43];
    text_char  = in_tdata[55:48];
    tick     = 1'b0;
    restart  = 1'b0;
    text_we  = 1'b0;
    glyph_we = 1'b0;
    unique case (cmd)
      sfg_pkg::CMD_LOAD_GLYPH:
        glyph_we = in_acc && (int'(glyph_code) < sfg_pkg::GLYPH_ENTRIES);
      sfg_pkg::CMD_LOAD_TEXT:
        text_we = in_acc && (int'(text_pos) < sfg_pkg::MAX_CHARS);
      sfg_pkg::CMD_PIXEL:
        tick = in_acc;
      sfg_pkg::CMD_RESTART:
        restart = in_acc;
      default: ;
    endcase
  end

  assign in_tready = adv;

  sfg_raster u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (tick),
    .restart   (restart),
    .scale_eff (scale_eff),
    .len_eff   (len_eff),
    .char_idx  (char_idx),
    .info      (info)
  );

  sfg_glyph_lookup u_lookup (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .tick       (tick),
    .info_in    (info),
    .char_idx   (char_idx),
    .text_we    (text_we),
    .text_addr  (sfg_pkg::CHAR_AW'(text_pos)),
    .text_data  (text_char),
    .glyph_we   (glyph_we),
    .glyph_addr (sfg_pkg::GLYPH_AW'(glyph_code)),
    .glyph_data (glyph_cols),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfg_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .fg_color   (fg_r),
    .bg_color   (bg_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_beat   (out_beat),
    .adv        (adv)
  );

  assign out_tdata = out_beat.color;
  assign out_tlast = out_beat.row_end;
  assign out_tuser = out_beat.window_end;

endmodule

`default_nettype wire

// ===== src/sfg_checker.sv =====
// port-level checker for the scaled font text pixel generator, bound to the top level
// depends on scaled_font_text_pixel_generator_assert.svh
`default_nettype none

`include "scaled_font_text_pixel_generator_assert.svh"

module sfg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  // last pixel of the window is also the last of its row
  `SFG_ASSERT_IMP(a_window_end_is_row_end, out_tvalid && out_tuser, out_tlast)

  // input only backs up when a result is waiting on the output
  `SFG_ASSERT_IMP(a_stall_needs_output, !in_tready, out_tvalid)

  // nothing leaves right after reset
  `SFG_ASSERT_NXT_ALL(a_reset_clears_output, !rst_n, !out_tvalid)

  // a stalled beat holds
  `SFG_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind scaled_font_text_pixel_generator sfg_checker u_sfg_checker (.*);

`default_nettype wire
